>>> src/wosc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wosc_pkg
// Shared types and constants of the waveform oscillator.
// ----------------------------------------------------------------------------
package wosc_pkg;

   localparam int RateW    = 18;
   localparam int FreqW    = 18;
   localparam int WaveSelW = 2;
   localparam int AmpW     = 16;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 18;
   localparam int SampleW  = 16;
   localparam int PosW     = 18;

   // shared serial divider
   localparam int DivNumW = 52;
   localparam int DivDenW = 18;
   localparam int DivQuoW = 18;
   localparam int DivCntW = 6;
   localparam logic [DivCntW-1:0] DivStepsShort = 6'd19;
   localparam logic [DivCntW-1:0] DivStepsLong  = 6'd52;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SAMPLE_RATE = 3'd0,
      CSR_FREQUENCY   = 3'd1,
      CSR_WAVEFORM    = 3'd2,
      CSR_AMPLITUDE   = 3'd3,
      CSR_ENABLE      = 3'd4
   } csr_index_type;

   typedef enum logic [WaveSelW-1:0] {
      WAVE_SAW      = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_TRIANGLE = 2'd2
   } wave_sel_type;

   typedef enum logic [1:0] {
      DIV_PERIOD = 2'd0,
      DIV_PHASE  = 2'd1,
      DIV_WRAP   = 2'd2
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PER_START,
      ST_PER_WAIT,
      ST_MUL,
      ST_PHASE_START,
      ST_PHASE_WAIT,
      ST_SHAPE,
      ST_SCALE,
      ST_SAT,
      ST_WRAP_START,
      ST_WRAP_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        accept;
      logic        div_start;
      div_sel_type div_sel;
      logic        cap_period;
      logic        cap_prod;
      logic        cap_phase;
      logic        cap_wave;
      logic        cap_scaled;
      logic        cap_result;
      logic        pos_update;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic enable;
      logic div_done;
      logic out_full;
   } status_type;

endpackage

>>> src/wosc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wosc_req_if
// Input channel: one sample tick item with its restart flag.
// ----------------------------------------------------------------------------
interface wosc_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

>>> src/wosc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wosc_rsp_if
// Result channel: one Q1.15 sample item.
// ----------------------------------------------------------------------------
interface wosc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

>>> src/wosc_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wosc_csr_if
// Register write channel: index and write data.
// ----------------------------------------------------------------------------
interface wosc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [17:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/waveform_oscillator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_oscillator_unit
// Saw, square and triangle oscillator producing one Q1.15 sample per tick.
// ----------------------------------------------------------------------------
// Each req item is one sample tick and returns exactly one rsp item, in
// order. With enable set, the time to a result is set by one shared
// restoring divider that makes one bit per cycle and runs three times per
// item (period ceil(rate/freq) in 19 steps, phase quotient
// 65536*pos*freq/rate in 52 steps, position wrap (pos+1) mod period in 19
// steps), plus the sequencing states around the divisions. With enable
// clear the sequencer goes from idle straight to the output state, which
// loads the zero sample into the output register, the position being held
// (restart still clears it). One item is worked on at a time; a new item
// is taken while the previous result still sits in the output register,
// and the sequencer only stalls when that register is still full at the
// end. Registers (index: sample_rate 0, frequency 1, waveform 2, amplitude
// 3, enable 4) are written on any csr valid, csr ready is always high, and
// they should only be changed while the block is idle.
// ----------------------------------------------------------------------------
module waveform_oscillator_unit
   import wosc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   wosc_csr_if.sink    csr_ch,
   wosc_req_if.sink    req_ch,
   wosc_rsp_if.source  rsp_ch
);

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type stat;
   logic       req_ready;

   // register writes are always taken
   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = req_ready;

   wosc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wosc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_ch.valid),
      .csr_index  (csr_ch.index),
      .csr_data   (csr_ch.data),
      .restart    (req_ch.restart),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_sample (rsp_ch.sample)
   );

endmodule

>>> src/wosc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wosc_div
// Restoring serial divider, one quotient bit per cycle, saturating quotient.
// ----------------------------------------------------------------------------
module wosc_div
   import wosc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DivNumW-1:0] numer,   // left aligned
   input  logic [DivDenW-1:0] denom,
   input  logic [DivCntW-1:0] steps,
   output logic               busy,
   output logic               done,
   output logic [DivQuoW-1:0] quot,
   output logic [DivDenW-1:0] rem
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic [DivNumW-1:0] num_ff, num_in;
   logic [DivDenW-1:0] den_ff, den_in;
   logic [DivDenW-1:0] rem_ff, rem_in;
   logic [DivQuoW-1:0] quo_ff, quo_in;
   logic               ovf_ff, ovf_in;

   logic [DivDenW:0]   rem_shift;
   logic [DivDenW:0]   rem_sub;
   logic               fits;

   always_comb begin
      rem_shift = {rem_ff, num_ff[DivNumW-1]};
      fits      = rem_shift >= {1'b0, den_ff};
      rem_sub   = rem_shift - {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits the divisor width
         rem_in = fits ? rem_sub[DivDenW-1:0] : rem_shift[DivDenW-1:0];
         quo_in = {quo_ff[DivQuoW-2:0], fits};
         ovf_in = ovf_ff | quo_ff[DivQuoW-1];
         num_in = {num_ff[DivNumW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DivCntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = ovf_ff ? '1 : quo_ff;
   assign rem  = rem_ff;

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

endmodule

>>> src/wosc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wosc_ctrl
// Sequencer of the oscillator: steps the datapath through one sample.
// ----------------------------------------------------------------------------
module wosc_ctrl
   import wosc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = stat.enable ? ST_PER_START : ST_OUT;
         end
         ST_PER_START:   state_in = ST_PER_WAIT;
         ST_PER_WAIT: begin
            if (stat.div_done) state_in = ST_MUL;
         end
         ST_MUL:         state_in = ST_PHASE_START;
         ST_PHASE_START: state_in = ST_PHASE_WAIT;
         ST_PHASE_WAIT: begin
            if (stat.div_done) state_in = ST_SHAPE;
         end
         ST_SHAPE:       state_in = ST_SCALE;
         ST_SCALE:       state_in = ST_SAT;
         ST_SAT:         state_in = ST_WRAP_START;
         ST_WRAP_START:  state_in = ST_WRAP_WAIT;
         ST_WRAP_WAIT: begin
            if (stat.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!stat.out_full) state_in = ST_IDLE;
         end
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.div_sel = DIV_PERIOD;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_PER_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_PERIOD;
         end
         ST_PER_WAIT:    cmd.cap_period = stat.div_done;
         ST_MUL:         cmd.cap_prod   = 1'b1;
         ST_PHASE_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_PHASE;
         end
         ST_PHASE_WAIT:  cmd.cap_phase  = stat.div_done;
         ST_SHAPE:       cmd.cap_wave   = 1'b1;
         ST_SCALE:       cmd.cap_scaled = 1'b1;
         ST_SAT:         cmd.cap_result = 1'b1;
         ST_WRAP_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_WRAP;
         end
         ST_WRAP_WAIT:   cmd.pos_update = stat.div_done;
         ST_OUT:         cmd.out_load   = !stat.out_full;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/wosc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wosc_dp
// Oscillator datapath: registers, phase, wave shaping, gain and output stage.
// ----------------------------------------------------------------------------
module wosc_dp
   import wosc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic [CsrIdxW-1:0]        csr_index,
   input  logic [CsrDataW-1:0]       csr_data,
   input  logic                      restart,
   input  cmd_type                   cmd,
   output status_type                stat,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic signed [SampleW-1:0] rsp_sample
);

   function automatic logic signed [SampleW-1:0] sat16(input logic signed [19:0] v);
      logic signed [SampleW-1:0] r;
      if (v > 20'sd32767)       r = 16'sh7FFF;
      else if (v < -20'sd32768) r = 16'sh8000;
      else                      r = v[SampleW-1:0];
      return r;
   endfunction

   // configuration
   logic [RateW-1:0]    sr_ff, sr_in;
   logic [FreqW-1:0]    freq_ff, freq_in;
   logic [WaveSelW-1:0] wsel_ff, wsel_in;
   logic [AmpW-1:0]     amp_ff, amp_in;
   logic                enable_ff, enable_in;

   // working registers
   logic [PosW-1:0]           pos_ff, pos_in;
   logic [DivQuoW-1:0]        period_ff, period_in;
   logic [PosW+FreqW-1:0]     prod_ff, prod_in;
   logic [DivQuoW-1:0]        phase_ff, phase_in;
   logic signed [SampleW-1:0] wave_ff, wave_in;
   logic signed [32:0]        scaled_ff, scaled_in;
   logic signed [SampleW-1:0] res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SampleW-1:0] rsp_sample_ff, rsp_sample_in;

   logic [RateW-1:0]    sr_eff;
   logic [FreqW-1:0]    f_eff;
   logic [RateW:0]      per_num;
   logic [PosW:0]       pos_inc;
   logic signed [19:0]  phase_diff;
   logic signed [19:0]  dist_abs;
   logic signed [19:0]  tri_val;
   logic                sq_high;
   logic signed [17:0]  quot_q;

   logic [DivNumW-1:0] div_num;
   logic [DivDenW-1:0] div_den;
   logic [DivCntW-1:0] div_steps;
   logic               div_busy;
   logic               div_done;
   logic [DivQuoW-1:0] div_quot;
   logic [DivDenW-1:0] div_rem;

   // zero rate or frequency behaves as one
   assign sr_eff  = (sr_ff == '0) ? RateW'(1) : sr_ff;
   assign f_eff   = (freq_ff == '0) ? FreqW'(1) : freq_ff;
   assign per_num = (RateW+1)'(sr_eff) + (RateW+1)'(f_eff) - (RateW+1)'(1);
   assign pos_inc = (PosW+1)'(pos_ff) + (PosW+1)'(1);

   always_comb begin
      div_num   = {per_num, (DivNumW-RateW-1)'(0)};
      div_den   = f_eff;
      div_steps = DivStepsShort;
      case (cmd.div_sel)
         DIV_PERIOD: begin
            div_num   = {per_num, (DivNumW-RateW-1)'(0)};
            div_den   = f_eff;
            div_steps = DivStepsShort;
         end
         DIV_PHASE: begin
            div_num   = {prod_ff, 16'h0000};
            div_den   = sr_eff;
            div_steps = DivStepsLong;
         end
         DIV_WRAP: begin
            div_num   = {pos_inc, (DivNumW-PosW-1)'(0)};
            div_den   = period_ff;
            div_steps = DivStepsShort;
         end
         default: ;
      endcase
   end

   wosc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (div_num),
      .denom (div_den),
      .steps (div_steps),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   // wave shaping from the saturated phase quotient
   always_comb begin
      phase_diff = $signed({2'b00, phase_ff}) - 20'sd32768;
      dist_abs   = (phase_diff < 0) ? -phase_diff : phase_diff;
      tri_val    = 20'sd32768 - dist_abs;
      sq_high    = {prod_ff, 1'b0} < (PosW+FreqW+1)'(sr_eff);
      case (wsel_ff)
         WAVE_SAW:      wave_in = sat16(phase_diff);
         WAVE_SQUARE:   wave_in = sq_high ? 16'sh7FFF : 16'sh8000;
         WAVE_TRIANGLE: wave_in = sat16(tri_val);
         default:       wave_in = '0;
      endcase
   end

   // floor division by 32768 is an arithmetic shift
   assign quot_q = scaled_ff[32:15];

   always_comb begin
      sr_in     = sr_ff;
      freq_in   = freq_ff;
      wsel_in   = wsel_ff;
      amp_in    = amp_ff;
      enable_in = enable_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SAMPLE_RATE: sr_in     = csr_data[RateW-1:0];
            CSR_FREQUENCY:   freq_in   = csr_data[FreqW-1:0];
            CSR_WAVEFORM:    wsel_in   = csr_data[WaveSelW-1:0];
            CSR_AMPLITUDE:   amp_in    = csr_data[AmpW-1:0];
            CSR_ENABLE:      enable_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_in        = pos_ff;
      period_in     = cmd.cap_period ? div_quot : period_ff;
      prod_in       = cmd.cap_prod ? (PosW+FreqW)'(pos_ff) * (PosW+FreqW)'(f_eff) : prod_ff;
      phase_in      = cmd.cap_phase ? div_quot : phase_ff;
      scaled_in     = cmd.cap_scaled ? 33'(wave_ff) * $signed({17'b0, amp_ff}) : scaled_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;

      if (cmd.accept) begin
         if (restart) pos_in = '0;
         res_in = '0;
      end
      if (cmd.pos_update) pos_in = div_rem;
      if (cmd.cap_result) res_in = sat16(20'(quot_q));

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_ff        <= RateW'(48000);
         freq_ff      <= FreqW'(440);
         wsel_ff      <= WAVE_SAW;
         amp_ff       <= AmpW'(32768);
         enable_ff    <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sr_ff        <= sr_in;
         freq_ff      <= freq_in;
         wsel_ff      <= wsel_in;
         amp_ff       <= amp_in;
         enable_ff    <= enable_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      period_ff     <= period_in;
      prod_ff       <= prod_in;
      phase_ff      <= phase_in;
      wave_ff       <= cmd.cap_wave ? wave_in : wave_ff;
      scaled_ff     <= scaled_in;
      res_ff        <= res_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign stat.enable   = enable_ff;
   assign stat.div_done = div_done;
   assign stat.out_full = rsp_valid_ff;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   a_wrap_in_period: assert property (@(posedge clock) disable iff (reset)
      cmd.pos_update |-> (div_rem < period_ff))
      else $error("advanced position not below period");

   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_start && cmd.div_sel == DIV_WRAP) |-> (period_ff != '0 && !div_busy))
      else $error("wrap division with zero period");

   a_zero_when_off: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && !enable_ff) |=> (rsp_sample_ff == '0))
      else $error("nonzero sample while disabled");

endmodule

>>> verif/waveform_oscillator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_oscillator_unit_tb
// Self-checking bench for the saw, square and triangle oscillator. A local
// oscillator model tracks the register values and the phase position, and
// predicts one sample per accepted tick. Each result item is compared with
// the oldest prediction. Directed checks come first, then random register
// settings with bursts of ticks, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module waveform_oscillator_unit_tb
   import wosc_pkg::*;
();

   localparam longint Q15One     = 32768;
   localparam longint SampleMax  = 32767;
   localparam longint SampleMin  = -32768;
   localparam int     SettleCycles = 8;
   localparam logic [WaveSelW-1:0] WaveUnused = 2'd3;

   logic clock;
   logic reset;

   wosc_csr_if csr_bus ();
   wosc_req_if req_bus ();
   wosc_rsp_if rsp_bus ();

   waveform_oscillator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_bus),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // register mirror, starts at the reset values
   logic [RateW-1:0]    rate_reg   = 18'd48000;
   logic [FreqW-1:0]    freq_reg   = 18'd440;
   logic [WaveSelW-1:0] wave_reg   = WAVE_SAW;
   logic [AmpW-1:0]     amp_reg    = 16'd32768;
   logic                enable_reg = 1'b0;
   logic [PosW-1:0]     phase_pos  = '0;

   logic signed [SampleW-1:0] expected_samples[$];
   logic signed [SampleW-1:0] want_sample;
   int fail_count    = 0;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // clamp to the signed 16-bit sample range
   function automatic longint clamp_q15(input longint value);
      if (value > SampleMax) return SampleMax;
      if (value < SampleMin) return SampleMin;
      return value;
   endfunction

   // next oscillator sample for one tick, advances the phase position
   function automatic logic signed [SampleW-1:0] osc_next_sample(input logic restart);
      longint unsigned rate_eff, freq_eff, period, pos_u, scaled;
      longint          diff, wave, prod;
      logic signed [SampleW-1:0] result;
      result = '0;
      if (restart) phase_pos = '0;
      if (enable_reg) begin
         // a zero rate or frequency acts as one
         rate_eff = (rate_reg == 0) ? 1 : rate_reg;
         freq_eff = (freq_reg == 0) ? 1 : freq_reg;
         period   = (rate_eff + freq_eff - 1) / freq_eff;
         pos_u    = phase_pos;
         scaled   = (pos_u * freq_eff * 65536) / rate_eff;
         diff     = longint'(scaled) - Q15One;
         case (wave_reg)
            WAVE_SAW:      wave = clamp_q15(diff);
            WAVE_SQUARE:   wave = (2 * pos_u * freq_eff < rate_eff) ? SampleMax : SampleMin;
            WAVE_TRIANGLE: wave = clamp_q15(Q15One - ((diff < 0) ? -diff : diff));
            default:       wave = 0;   // unused code: silent but still advancing
         endcase
         // floor division by one in Q1.15, then saturate
         prod   = wave * longint'(amp_reg);
         result = SampleW'(clamp_q15(prod >>> 15));
         phase_pos = PosW'((pos_u + 1) % period);
      end
      return result;
   endfunction

   // register writes seen on the csr channel
   always @(posedge clock) begin
      if (!reset && csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_SAMPLE_RATE: rate_reg   = csr_bus.data[RateW-1:0];
            CSR_FREQUENCY:   freq_reg   = csr_bus.data[FreqW-1:0];
            CSR_WAVEFORM:    wave_reg   = csr_bus.data[WaveSelW-1:0];
            CSR_AMPLITUDE:   amp_reg    = csr_bus.data[AmpW-1:0];
            CSR_ENABLE:      enable_reg = csr_bus.data[0];
            default: ;   // indexes beyond the list are ignored
         endcase
      end
   end

   // predict on every accepted tick item
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         expected_samples.push_back(osc_next_sample(req_bus.restart));
   end

   // compare each result item with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_samples.size() == 0) begin
            fail_count++;
            $display("%0t unexpected sample: expected none, actual %0d",
                     $time, rsp_bus.sample);
         end else begin
            want_sample = expected_samples.pop_front();
            if (rsp_bus.sample !== want_sample) begin
               fail_count++;
               $display("%0t sample mismatch: expected %0d, actual %0d",
                        $time, want_sample, rsp_bus.sample);
            end
         end
      end
   end

   // result side back-pressure
   always @(posedge clock)
      rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   // send one tick item, with random idle cycles ahead of it
   task automatic send_tick(input logic restart);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_bus.valid   <= 1'b1;
      req_bus.restart <= restart;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // hold the sender until every predicted sample has come back
   task automatic wait_idle;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // register write, only with the block idle
   task automatic set_reg(input logic [CsrIdxW-1:0] index, input logic [CsrDataW-1:0] value);
      wait_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // reset values leave the block disabled: zero samples, restart still taken
   task automatic test_disabled_after_reset;
      send_tick(1'b0);
      send_tick(1'b1);
   endtask

   task automatic test_wave_shapes;
      set_reg(CSR_ENABLE, 18'd1);
      repeat (3) send_tick(1'b0);          // saw at the reset rate and frequency
      set_reg(CSR_FREQUENCY, 18'd12000);   // period of four ticks
      set_reg(CSR_WAVEFORM, CsrDataW'(WAVE_SQUARE));
      repeat (2) send_tick(1'b0);
      set_reg(CSR_WAVEFORM, CsrDataW'(WAVE_TRIANGLE));
      repeat (2) send_tick(1'b0);
      set_reg(CSR_WAVEFORM, CsrDataW'(WaveUnused));
      send_tick(1'b0);
   endtask

   task automatic test_gain_and_rate_extremes;
      set_reg(CSR_WAVEFORM, CsrDataW'(WAVE_SQUARE));
      set_reg(CSR_AMPLITUDE, 18'd0);
      send_tick(1'b0);
      // gain above one saturates the product
      set_reg(CSR_AMPLITUDE, 18'h0FFFF);
      send_tick(1'b0);
      // zero rate and frequency act as one
      set_reg(CSR_SAMPLE_RATE, 18'd0);
      set_reg(CSR_FREQUENCY, 18'd0);
      send_tick(1'b0);
      set_reg(CSR_SAMPLE_RATE, 18'd1);
      set_reg(CSR_FREQUENCY, 18'h3FFFF);
      send_tick(1'b0);
   endtask

   // position left beyond a shortened period
   task automatic test_position_beyond_period;
      set_reg(CSR_AMPLITUDE, 18'd32768);
      set_reg(CSR_WAVEFORM, CsrDataW'(WAVE_SAW));
      set_reg(CSR_SAMPLE_RATE, 18'd192000);
      set_reg(CSR_FREQUENCY, 18'd7);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
      set_reg(CSR_FREQUENCY, 18'd192000);
      send_tick(1'b0);
   endtask

   task automatic test_restart_cases;
      set_reg(CSR_FREQUENCY, 18'd3);
      send_tick(1'b0);
      send_tick(1'b1);
      // restart while disabled still clears the position
      set_reg(CSR_ENABLE, 18'd0);
      send_tick(1'b1);
      set_reg(CSR_ENABLE, 18'd1);
      send_tick(1'b0);
      send_tick(1'b0);
      // writes beyond the register list change nothing
      for (int idx = int'(CSR_ENABLE) + 1; idx < (1 << CsrIdxW); idx++)
         set_reg(CsrIdxW'(idx), CsrDataW'($urandom));
      send_tick(1'b0);
   endtask

   // random settings, each followed by a burst of ticks
   task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
      logic [RateW-1:0]    rate_val;
      logic [FreqW-1:0]    freq_val;
      logic [AmpW-1:0]     amp_val;
      logic [WaveSelW-1:0] wave_val;
      int  rate_eff;
      int  sent;
      int  burst;
      bit  write_all;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      sent      = 0;
      write_all = 1'b1;
      while (sent < n_items) begin
         case ($urandom_range(0, 15))
            0:       rate_val = '0;
            1:       rate_val = '1;
            2:       rate_val = 18'd1;
            3:       rate_val = 18'd192000;
            default: rate_val = RateW'($urandom_range(8000, 192000));
         endcase
         rate_eff = (rate_val == 0) ? 1 : rate_val;
         case ($urandom_range(0, 15))
            0:       freq_val = '0;
            1:       freq_val = '1;
            2:       freq_val = FreqW'(rate_eff + $urandom_range(0, 1000));   // period one
            3:       freq_val = FreqW'($urandom_range(1, 2000));              // long period
            default: freq_val = FreqW'(rate_eff / $urandom_range(2, 48) + $urandom_range(0, 3));
         endcase
         case ($urandom_range(0, 7))
            0:       amp_val = '0;
            1:       amp_val = 16'd32768;
            2:       amp_val = '1;
            3:       amp_val = AmpW'($urandom_range(0, 65535));
            default: amp_val = AmpW'($urandom_range(0, 32768));
         endcase
         wave_val = ($urandom_range(0, 9) == 0) ? WaveUnused
                                                : WaveSelW'($urandom_range(0, 2));
         // a skipped write keeps the old value and the position carries over
         if (write_all || $urandom_range(0, 9) < 7) set_reg(CSR_SAMPLE_RATE, rate_val);
         if (write_all || $urandom_range(0, 9) < 7) set_reg(CSR_FREQUENCY, freq_val);
         if (write_all || $urandom_range(0, 9) < 7)
            set_reg(CSR_WAVEFORM, {16'($urandom), wave_val});
         if (write_all || $urandom_range(0, 9) < 7)
            set_reg(CSR_AMPLITUDE, {2'($urandom), amp_val});
         if (write_all || $urandom_range(0, 9) < 7)
            set_reg(CSR_ENABLE, {17'($urandom), ($urandom_range(0, 9) != 0)});
         if ($urandom_range(0, 19) == 0)
            set_reg(CsrIdxW'($urandom_range(int'(CSR_ENABLE) + 1, (1 << CsrIdxW) - 1)),
                    CsrDataW'($urandom));
         write_all = 1'b0;
         burst = $urandom_range(4, 40);
         for (int i = 0; i < burst && sent < n_items; i++) begin
            send_tick($urandom_range(0, 99) < 10);
            sent++;
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.restart = 1'b0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = '0;
      csr_bus.data    = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed checks, no idling
      test_disabled_after_reset();
      test_wave_shapes();
      test_gain_and_rate_extremes();
      test_position_beyond_period();
      test_restart_cases();

      // random phases: free flow, idle sender, stalling receiver, both
      test_random_traffic(150, 0, 0);
      test_random_traffic(120, 83, 0);
      test_random_traffic(120, 0, 83);
      test_random_traffic(110, 20, 20);

      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("waveform_oscillator_unit regression: pass");
      else
         $display("waveform_oscillator_unit regression: fail");
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #(2_000_000);
      $display("waveform_oscillator_unit regression: fail");
      $finish;
   end

endmodule
